[rtl/core/first_fit_page_bump_allocator_macros.svh]
// Assertion macros for the first-fit page bump allocator.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef FIRST_FIT_PAGE_BUMP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_PAGE_BUMP_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while in reset.
`define FFPBA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while in reset.
`define FFPBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FFPBA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define FFPBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/ffpba_pkg.sv]
// Shared types and constants of the first-fit page bump allocator.
// No dependencies; used by first_fit_page_bump_allocator.
package ffpba_pkg;

    localparam int ADDR_W = 32;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [1:0]        status_t;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_TOO_BIG = 2'd1;
    localparam status_t ST_NO_PAGE = 2'd2;

endpackage

[rtl/core/first_fit_page_bump_allocator.sv]
// First-fit page bump allocator, top level.
// Depends on ffpba_pkg and first_fit_page_bump_allocator_macros.svh.
//
// Usage: raise start with request_bytes while busy is low; the word is taken at
// that edge. Exactly one result word follows, shown for one cycle with done high;
// the receiver cannot stall, so sample it when done is seen. A request larger
// than PAGE_BYTES answers in the cycle after acceptance without going busy.
// Any other request scans the used byte counts of the pages in use, one page per
// cycle out of a used-count memory with a registered read, and answers from the
// first page that fits. If none fits and fewer than MAX_PAGES pages are in use,
// a new page is appended (the APPEND state writes the new page's count; with no
// pages in use it is appended at once); else the page limit is reached and the
// request is refused. done is high in the first cycle with busy low, so the next
// request may be taken while the result shows.
// The heap base address is written through the cfg channel (cfg_ready is always
// high) and must only change while idle.
// Used counts of pages not yet appended are never read, so the memory needs no
// clearing pass after reset.
`include "first_fit_page_bump_allocator_macros.svh"

module first_fit_page_bump_allocator #(
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_PAGES  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  start,
    output logic                  busy,
    input  logic [31:0]           request_bytes,
    // result channel
    output logic                  done,
    output logic                  granted,
    output ffpba_pkg::addr_t      block_address,
    output ffpba_pkg::status_t    status,
    output logic                  page_added,
    output ffpba_pkg::addr_t      new_page_address,
    // configuration channel: heap base address
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [31:0]           cfg_data
);

    // Width of one used count, able to hold PAGE_BYTES itself.
    localparam int UW = $clog2(PAGE_BYTES + 1);
    // Page index width and page count width.
    localparam int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CW = $clog2(MAX_PAGES + 1);

    localparam logic [31:0]   PAGE_LIMIT = 32'(PAGE_BYTES);
    localparam logic [UW:0]   PAGE_FULL  = (UW+1)'(PAGE_BYTES);
    localparam logic [CW-1:0] PAGE_MAX   = CW'(MAX_PAGES);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_APPEND = 2'd2;

    // Control state
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] pages_reg, pages_next;
    logic          done_reg, done_next;

    // Working registers
    logic [IW-1:0]    idx_reg, idx_next;
    logic [UW-1:0]    req_reg, req_next;
    ffpba_pkg::addr_t page_addr_reg, page_addr_next;
    ffpba_pkg::addr_t base_addr_reg;

    // Result word
    logic               granted_reg, granted_next;
    ffpba_pkg::addr_t   addr_reg, addr_next;
    ffpba_pkg::status_t status_reg, status_next;
    logic               added_reg, added_next;
    ffpba_pkg::addr_t   new_addr_reg, new_addr_next;

    // Used-count memory
    logic [UW-1:0] used_mem [MAX_PAGES];
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [UW-1:0] rd_data_reg;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [UW-1:0] wr_data;

    logic [UW:0]   fit_sum;
    logic          fits;
    logic [CW-1:0] idx_succ;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign done             = done_reg;
    assign granted          = granted_reg;
    assign block_address    = addr_reg;
    assign status           = status_reg;
    assign page_added       = added_reg;
    assign new_page_address = new_addr_reg;

    // Room check for the page whose count just came out of the memory.
    assign fit_sum  = {1'b0, rd_data_reg} + {1'b0, req_reg};
    assign fits     = (fit_sum <= PAGE_FULL);
    assign idx_succ = CW'(idx_reg) + CW'(1);

    always_comb
    begin
        state_next     = state_reg;
        pages_next     = pages_reg;
        done_next      = 1'b0;
        idx_next       = idx_reg;
        req_next       = req_reg;
        page_addr_next = page_addr_reg;
        granted_next   = granted_reg;
        addr_next      = addr_reg;
        status_next    = status_reg;
        added_next     = added_reg;
        new_addr_next  = new_addr_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = fit_sum[UW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next       = request_bytes[UW-1:0];
                    page_addr_next = base_addr_reg;
                    idx_next       = '0;
                    if (request_bytes > PAGE_LIMIT)
                    begin
                        // Refuse at once; the FSM state does not change.
                        done_next     = 1'b1;
                        granted_next  = 1'b0;
                        addr_next     = '0;
                        status_next   = ffpba_pkg::ST_TOO_BIG;
                        added_next    = 1'b0;
                        new_addr_next = '0;
                    end
                    else if (pages_reg == '0)
                    begin
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        // Fetch page 0's used count.
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (fits)
                begin
                    // Bump this page and answer.
                    wr_en         = 1'b1;
                    wr_addr       = idx_reg;
                    wr_data       = fit_sum[UW-1:0];
                    done_next     = 1'b1;
                    granted_next  = 1'b1;
                    addr_next     = page_addr_reg + 32'(rd_data_reg);
                    status_next   = ffpba_pkg::ST_OK;
                    added_next    = 1'b0;
                    new_addr_next = '0;
                    state_next    = S_IDLE;
                end
                else if (idx_succ < pages_reg)
                begin
                    // Advance to the next page.
                    rd_en          = 1'b1;
                    rd_addr        = idx_succ[IW-1:0];
                    idx_next       = idx_succ[IW-1:0];
                    page_addr_next = page_addr_reg + PAGE_LIMIT;
                end
                else if (pages_reg == PAGE_MAX)
                begin
                    done_next     = 1'b1;
                    granted_next  = 1'b0;
                    addr_next     = '0;
                    status_next   = ffpba_pkg::ST_NO_PAGE;
                    added_next    = 1'b0;
                    new_addr_next = '0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    page_addr_next = page_addr_reg + PAGE_LIMIT;
                    state_next     = S_APPEND;
                end
            end
            S_APPEND:
            begin
                // New page starts at zero used, so its count becomes the request.
                wr_en         = 1'b1;
                wr_addr       = pages_reg[IW-1:0];
                wr_data       = req_reg;
                pages_next    = pages_reg + CW'(1);
                done_next     = 1'b1;
                granted_next  = 1'b1;
                addr_next     = page_addr_reg;
                status_next   = ffpba_pkg::ST_OK;
                added_next    = 1'b1;
                new_addr_next = page_addr_reg;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pages_reg     <= '0;
            done_reg      <= 1'b0;
            base_addr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pages_reg <= pages_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                base_addr_reg <= cfg_data;
            end
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        req_reg       <= req_next;
        page_addr_reg <= page_addr_next;
        granted_reg   <= granted_next;
        addr_reg      <= addr_next;
        status_reg    <= status_next;
        added_reg     <= added_next;
        new_addr_reg  <= new_addr_next;
    end

    // Used-count memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            used_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= used_mem[rd_addr];
        end
    end

    `FFPBA_ASSERT_SAME(a_grant_ok, clk, rst_n, done && granted,
        status == ffpba_pkg::ST_OK, "granted word with error status")
    `FFPBA_ASSERT_SAME(a_refuse_clean, clk, rst_n, done && !granted,
        (block_address == '0) && !page_added && (status != ffpba_pkg::ST_OK),
        "refused word carries an address")
    `FFPBA_ASSERT_SAME(a_added_addr, clk, rst_n, done && page_added,
        granted && (new_page_address == block_address), "appended page address mismatch")
    `FFPBA_ASSERT_SAME(a_page_bound, clk, rst_n, 1'b1, pages_reg <= PAGE_MAX,
        "page count beyond limit")
    `FFPBA_ASSERT_NEXT(a_append_done, clk, rst_n, state_reg == S_APPEND,
        done && page_added && !busy, "append did not answer")

endmodule
